FILE: hdl/pnguf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the png scanline unfilter
// no dependencies

package pnguf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_ROW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 2'd2;

    // register widths
    localparam int BPP_W  = 3;
    localparam int PPR_W  = 13;
    localparam int ROWS_W = 16;

    localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

    // png filter type codes
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // neighbor bytes of the sample being reconstructed
    typedef struct packed {
        logic [7:0] left;
        logic [7:0] above;
        logic [7:0] upper_left;
    } nbr_t;

endpackage

FILE: hdl/pnguf_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module pnguf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/pnguf_predict.sv
`timescale 1ns / 1ps
// png filter predictor and byte reconstruction
// depends on pnguf_pkg

module pnguf_predict
    import pnguf_pkg::*;
(
    input  filt_t      filt,
    input  nbr_t       nbr,
    input  logic [7:0] x,
    output logic [7:0] y
);

    logic signed [9:0] sa, sb, sc;
    logic signed [9:0] da, db, dc;
    logic        [9:0] pa, pb, pc;
    logic        [8:0] avg_sum;
    logic        [7:0] paeth;
    logic        [7:0] pred;

    // paeth distances on 10-bit signed values
    always_comb
    begin
        sa = signed'({2'b00, nbr.left});
        sb = signed'({2'b00, nbr.above});
        sc = signed'({2'b00, nbr.upper_left});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - (sc <<< 1);
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
        begin
            paeth = nbr.left;
        end
        else if (pb <= pc)
        begin
            paeth = nbr.above;
        end
        else
        begin
            paeth = nbr.upper_left;
        end
    end

    assign avg_sum = {1'b0, nbr.left} + {1'b0, nbr.above};

    always_comb
    begin
        unique case (filt)
            FILT_SUB:   pred = nbr.left;
            FILT_UP:    pred = nbr.above;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

    // modulo 256 by truncation
    assign y = x + pred;

endmodule

FILE: hdl/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// top level of the png scanline unfilter: byte stream in, reconstructed samples out
// depends on pnguf_pkg, pnguf_ram, pnguf_predict

// Takes one inflated png byte per transaction. The first byte of each row is the
// filter type, then pixels_per_row * bytes_per_pixel filtered bytes follow; each
// sample byte yields one output transaction, the filter type byte yields none.
// Throughput is one byte per clock with no bubbles unless out_stall holds the
// output register: the only loop is the left-neighbor feedback through the
// reconstruct stage. An input transaction is registered in the reconstruct stage,
// beside the registered read of the line store ram, then in the output register.
// The line store holds the previous row; it is never swept on an image boundary,
// instead a fill count marks how much of it the current image has written and any
// entry beyond it reads as zero, so there is no clearing pass after reset or
// between images. Filter types above 4 raise bad_filter on every byte of that row
// and the row is passed through unfiltered. Configuration may only be written while
// no transaction is in flight.

module png_scanline_unfilter
    import pnguf_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 16384
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // input byte stream
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            filtered_byte,
    // reconstructed samples
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            pixel_byte,
    output logic                  end_of_row,
    output logic                  end_of_image,
    output logic                  bad_filter,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // column index covers 0 .. MAX_ROW_BYTES-1, row length and fill count reach it
    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int RB_W   = $clog2(MAX_ROW_BYTES + 1);
    localparam int PROD_W = PPR_W + BPP_W;
    localparam int SAT_W  = (RB_W > PROD_W) ? RB_W : PROD_W;

    // configuration registers
    logic [BPP_W-1:0]  bpp_reg;
    logic [PPR_W-1:0]  ppr_reg;
    logic [ROWS_W-1:0] rows_reg;

    // row tracking, updated on every accepted byte
    logic              awaiting_reg, awaiting_next;
    filt_t             row_filt_reg, row_filt_next;
    logic              row_bad_reg, row_bad_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROWS_W-1:0] row_idx_reg, row_idx_next;
    logic [RB_W-1:0]   fill_reg, fill_next;

    // reconstruct stage
    logic              s1_valid_reg;
    logic              s1_sample_reg;
    logic [7:0]        s1_x_reg;
    filt_t             s1_filt_reg;
    logic              s1_bad_reg;
    logic              s1_eor_reg;
    logic              s1_eoi_reg;
    logic              s1_bvalid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [1:0]        s1_bsel_reg;

    // last four reconstructed bytes of this row and the bytes above them
    logic [31:0]       left_hist_reg;
    logic [31:0]       ul_hist_reg;

    // output register
    logic              out_valid_reg;
    logic [7:0]        pixel_byte_reg;
    logic              end_of_row_reg;
    logic              end_of_image_reg;
    logic              bad_filter_reg;

    logic              accept;
    logic              sample_accept;
    logic              out_free;
    logic              s1_adv;
    logic              s1_emit;

    logic [BPP_W-1:0]  bpp_eff;
    logic [PPR_W-1:0]  ppr_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [PROD_W-1:0] prod;
    logic [SAT_W-1:0]  prod_ext;
    logic [RB_W-1:0]   row_bytes;
    logic [RB_W-1:0]   col_inc;
    logic              eor;
    logic              eoi;
    logic [ROWS_W-1:0] row_idx_inc;
    logic              type_bad;
    logic              bvalid;

    logic [7:0]        ram_rd_data;
    nbr_t              nbr;
    logic [7:0]        recon;

    // ------------------------------------------------------------------
    // handshake: the reconstruct stage drains into the output register, a
    // filter type byte leaves the stage without needing it
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || !out_stall;
    assign s1_adv        = s1_valid_reg && (!s1_sample_reg || out_free);
    assign s1_emit       = s1_adv && s1_sample_reg;
    assign in_stall      = s1_valid_reg && !s1_adv;
    assign accept        = in_valid && !in_stall;
    assign sample_accept = accept && !awaiting_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg  <= BPP_W'(1);
            ppr_reg  <= PPR_W'(1);
            rows_reg <= ROWS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL: bpp_reg  <= cfg_data[BPP_W-1:0];
                CFG_PIXELS_PER_ROW:  ppr_reg  <= cfg_data[PPR_W-1:0];
                CFG_ROW_COUNT:       rows_reg <= cfg_data[ROWS_W-1:0];
                default:             ;
            endcase
        end
    end

    // out-of-range settings are clamped, row length saturates at the line store size
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            bpp_eff = BPP_W'(1);
        end
        else if (bpp_reg > BPP_MAX)
        begin
            bpp_eff = BPP_MAX;
        end
        else
        begin
            bpp_eff = bpp_reg;
        end
        ppr_eff  = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
        rows_eff = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
        prod     = PROD_W'(ppr_eff) * PROD_W'(bpp_eff);
        prod_ext = SAT_W'(prod);
        if (prod_ext > SAT_W'(MAX_ROW_BYTES))
        begin
            row_bytes = RB_W'(MAX_ROW_BYTES);
        end
        else
        begin
            row_bytes = prod_ext[RB_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // row and column tracking at the input transaction
    // ------------------------------------------------------------------
    assign col_inc     = RB_W'(col_reg) + RB_W'(1);
    assign eor         = col_inc >= row_bytes;
    assign row_idx_inc = row_idx_reg + ROWS_W'(1);
    // row counter wrap to zero also closes the image
    assign eoi         = eor && ((row_idx_inc >= rows_eff) || (row_idx_inc == '0));
    assign type_bad    = filtered_byte > 8'(FILT_PAETH);
    // entries past the fill count belong to an earlier image and read as zero
    assign bvalid      = RB_W'(col_reg) < fill_reg;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        row_filt_next = row_filt_reg;
        row_bad_next  = row_bad_reg;
        col_next      = col_reg;
        row_idx_next  = row_idx_reg;
        fill_next     = fill_reg;
        if (accept)
        begin
            if (awaiting_reg)
            begin
                row_bad_next  = type_bad;
                row_filt_next = type_bad ? FILT_NONE : filt_t'(filtered_byte[2:0]);
                col_next      = '0;
                awaiting_next = 1'b0;
            end
            else
            begin
                if (col_inc > fill_reg)
                begin
                    fill_next = col_inc;
                end
                if (eor)
                begin
                    col_next      = '0;
                    awaiting_next = 1'b1;
                    row_idx_next  = row_idx_inc;
                    if (eoi)
                    begin
                        row_idx_next = '0;
                        fill_next    = '0;
                    end
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            row_filt_reg <= FILT_NONE;
            row_bad_reg  <= 1'b0;
            col_reg      <= '0;
            row_idx_reg  <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            row_filt_reg <= row_filt_next;
            row_bad_reg  <= row_bad_next;
            col_reg      <= col_next;
            row_idx_reg  <= row_idx_next;
            fill_reg     <= fill_next;
        end
    end

    // ------------------------------------------------------------------
    // line store: read the above byte at accept, write the result back
    // from the reconstruct stage; the two addresses never coincide
    // ------------------------------------------------------------------
    pnguf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_emit),
        .wr_addr (s1_col_reg),
        .wr_data (recon),
        .rd_en   (sample_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // reconstruct stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= !awaiting_reg;
            s1_x_reg      <= filtered_byte;
            s1_filt_reg   <= row_filt_reg;
            s1_bad_reg    <= row_bad_reg;
            s1_eor_reg    <= eor;
            s1_eoi_reg    <= eoi;
            s1_bvalid_reg <= bvalid;
            s1_col_reg    <= col_reg;
            s1_bsel_reg   <= 2'(bpp_eff - BPP_W'(1));
        end
    end

    // left and upper-left sit bytes_per_pixel back in the history words
    always_comb
    begin
        nbr.left       = left_hist_reg[8 * s1_bsel_reg +: 8];
        nbr.upper_left = ul_hist_reg[8 * s1_bsel_reg +: 8];
        nbr.above      = s1_bvalid_reg ? ram_rd_data : 8'd0;
    end

    pnguf_predict u_predict (
        .filt (s1_filt_reg),
        .nbr  (nbr),
        .x    (s1_x_reg),
        .y    (recon)
    );

    // a filter type byte clears the histories, so the row starts with zero neighbors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_hist_reg <= '0;
            ul_hist_reg   <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_sample_reg)
            begin
                left_hist_reg <= {left_hist_reg[23:0], recon};
                ul_hist_reg   <= {ul_hist_reg[23:0], nbr.above};
            end
            else
            begin
                left_hist_reg <= '0;
                ul_hist_reg   <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            pixel_byte_reg   <= recon;
            end_of_row_reg   <= s1_eor_reg;
            end_of_image_reg <= s1_eoi_reg;
            bad_filter_reg   <= s1_bad_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_byte   = pixel_byte_reg;
    assign end_of_row   = end_of_row_reg;
    assign end_of_image = end_of_image_reg;
    assign bad_filter   = bad_filter_reg;

endmodule

FILE: hdl/pnguf_checker.sv
`timescale 1ns / 1ps
// port-level checks for the png scanline unfilter, bound to the top level
// depends on png_scanline_unfilter

module pnguf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] pixel_byte,
    input logic       end_of_row,
    input logic       end_of_image,
    input logic       bad_filter
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable({pixel_byte, end_of_row, end_of_image, bad_filter}))
    else $error("result payload changed while stalled");

    // the last byte of an image is also the last byte of a row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_image |-> end_of_row)
    else $error("end of image without end of row");

    // with the output register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind png_scanline_unfilter pnguf_checker u_checker (.*);

FILE: bench/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// self-checking bench for png_scanline_unfilter: directed rows, a long wide row, random images
// depends on pnguf_pkg and the png_scanline_unfilter rtl; outputs are checked against a local predictor

module tb_png_scanline_unfilter;
    import pnguf_pkg::*;

    localparam int MAX_ROW_BYTES = 16384;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int WIDE_ITEMS    = 300;
    localparam int SETTLE_CYCLES = 4;       // pipeline settle plus margin
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_COST    = 300;     // largest image finished inside one random phase

    // one expected output transaction
    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
        logic       bad;
    } sample_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [7:0]            filtered_byte = 8'd0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [7:0]            pixel_byte;
    logic                  end_of_row;
    logic                  end_of_image;
    logic                  bad_filter;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_BYTES_PER_PIXEL;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    png_scanline_unfilter #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .filtered_byte(filtered_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_byte   (pixel_byte),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image),
        .bad_filter   (bad_filter),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // unfilter predictor: register copies plus the row state of the block
    // ------------------------------------------------------------------
    logic [BPP_W-1:0]  reg_bpp      = 3'd1;
    logic [PPR_W-1:0]  reg_ppr      = 13'd1;
    logic [ROWS_W-1:0] reg_rows     = 16'd1;
    logic [7:0]        line_store [MAX_ROW_BYTES];
    logic [31:0]       left_hist    = '0;   // last reconstructed bytes of this row
    logic [31:0]       upleft_hist  = '0;   // last above bytes, for the upper-left neighbor
    filt_t             row_filter   = FILT_NONE;
    logic              row_bad      = 1'b0;
    int unsigned       column       = 0;
    logic [15:0]       row_number   = '0;
    logic              await_filter = 1'b1;

    sample_t           expected_samples [$];
    logic [7:0]        pending_bytes [$];

    // stream planner: tracks where queued bytes land so images stay well formed
    logic              plan_await   = 1'b1;
    int unsigned       plan_column  = 0;
    logic [15:0]       plan_row     = '0;
    int unsigned       planned_bytes = 0;

    // handshake control shared by the initial block and the side processes
    logic              byte_taken   = 1'b0;
    logic              no_idle      = 1'b0;
    logic              hold_request = 1'b0;
    int                hold_left    = 0;
    int                mismatches   = 0;
    int                cycle_count  = 0;

    // out-of-range register values fold onto the nearest legal one
    function automatic int unsigned pixel_size();
        if (reg_bpp == 0)
            return 1;
        if (reg_bpp > BPP_MAX)
            return 4;
        return reg_bpp;
    endfunction

    // row length saturates at the line store depth
    function automatic int unsigned row_len();
        int unsigned w;
        w = (reg_ppr == 0) ? 1 : reg_ppr;
        w = w * pixel_size();
        return (w > MAX_ROW_BYTES) ? MAX_ROW_BYTES : w;
    endfunction

    function automatic int unsigned image_height();
        return (reg_rows == 0) ? 1 : reg_rows;
    endfunction

    function automatic void clear_line_store();
        foreach (line_store[i])
            line_store[i] = 8'd0;
    endfunction

    // paeth: nearest of left, above, upper-left to left + above - upper-left, ties in that order
    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int pa, pb, pc;
        pa = int'(b) - int'(c);
        pb = int'(a) - int'(c);
        pc = pa + pb;
        if (pa < 0)
            pa = -pa;
        if (pb < 0)
            pb = -pb;
        if (pc < 0)
            pc = -pc;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    // advance the predictor by one accepted byte, queueing the sample it yields
    function automatic void reconstruct_byte(input logic [7:0] x);
        int unsigned sz;
        logic [7:0]  a, b, c, guess;
        sample_t     s;
        if (await_filter)
        begin
            // filter type byte: no output, types above paeth run as none
            row_bad      = (x > 8'(FILT_PAETH));
            row_filter   = row_bad ? FILT_NONE : filt_t'(x[2:0]);
            column       = 0;
            left_hist    = '0;
            upleft_hist  = '0;
            await_filter = 1'b0;
            return;
        end
        sz = pixel_size();
        a  = 8'(left_hist >> (8 * (sz - 1)));
        c  = 8'(upleft_hist >> (8 * (sz - 1)));
        b  = line_store[column];
        case (row_filter)
            FILT_SUB:   guess = a;
            FILT_UP:    guess = b;
            FILT_AVG:   guess = 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH: guess = paeth_pick(a, b, c);
            default:    guess = 8'd0;
        endcase
        s.pixel     = x + guess;
        s.row_end   = 1'b0;
        s.image_end = 1'b0;
        s.bad       = row_bad;
        line_store[column] = s.pixel;
        left_hist   = {left_hist[23:0], s.pixel};
        upleft_hist = {upleft_hist[23:0], b};
        // a shrunk row length can leave the column past the end: this byte closes the row
        if (column + 1 >= row_len())
        begin
            s.row_end    = 1'b1;
            column       = 0;
            await_filter = 1'b1;
            row_number   = row_number + 16'd1;
            if (row_number >= image_height() || row_number == 16'd0)
            begin
                s.image_end = 1'b1;
                row_number  = '0;
                clear_line_store();
            end
        end
        else
            column++;
        expected_samples.push_back(s);
    endfunction

    function automatic void note_mismatch(input string field, input int want, input int got);
        mismatches++;
        $error("%s expected %0h got %0h", field, want, got);
    endfunction

    // ------------------------------------------------------------------
    // sampling at the rising edge: output check first, then the predictor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_check
        sample_t want;
        byte_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                $error("unexpected transaction, pixel_byte %0h", pixel_byte);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (pixel_byte !== want.pixel)
                    note_mismatch("pixel_byte", want.pixel, pixel_byte);
                if (end_of_row !== want.row_end)
                    note_mismatch("end_of_row", want.row_end, end_of_row);
                if (end_of_image !== want.image_end)
                    note_mismatch("end_of_image", want.image_end, end_of_image);
                if (bad_filter !== want.bad)
                    note_mismatch("bad_filter", want.bad, bad_filter);
            end
        end
        if (byte_taken)
            reconstruct_byte(filtered_byte);
    end

    // byte driver: a stalled byte is held, otherwise the next one goes out with ~10% gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || byte_taken)
        begin
            if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= 10))
            begin
                filtered_byte <= pending_bytes.pop_front();
                in_valid      <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // sample receiver: ~10% random stall, or a long counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 10);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register write, only issued with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BYTES_PER_PIXEL: reg_bpp  = value[BPP_W-1:0];
            CFG_PIXELS_PER_ROW:  reg_ppr  = value[PPR_W-1:0];
            CFG_ROW_COUNT:       reg_rows = value[ROWS_W-1:0];
            default:             ;
        endcase
    endtask

    // sender pause: everything sent, every sample back, pipeline settled
    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        plan_await  = await_filter;
        plan_column = column;
        plan_row    = row_number;
    endtask

    // queue one byte that fits the planned position: a filter type or a sample
    task automatic plan_step();
        if (plan_await)
        begin
            if ($urandom_range(99) < 85)
                pending_bytes.push_back(8'($urandom_range(int'(FILT_PAETH))));
            else
                pending_bytes.push_back(8'($urandom_range(255, int'(FILT_PAETH) + 1)));
            plan_await  = 1'b0;
            plan_column = 0;
        end
        else
        begin
            if ($urandom_range(99) < 15)
                pending_bytes.push_back($urandom_range(1) ? 8'hFF : 8'h00);
            else
                pending_bytes.push_back(8'($urandom_range(255)));
            if (plan_column + 1 >= row_len())
            begin
                plan_await  = 1'b1;
                plan_column = 0;
                plan_row    = plan_row + 16'd1;
                if (plan_row >= image_height() || plan_row == 16'd0)
                    plan_row = '0;
            end
            else
                plan_column++;
        end
        planned_bytes++;
    endtask

    // run the stream up to the start of the next image
    task automatic finish_image();
        while (!(plan_await && plan_row == 16'd0))
            plan_step();
    endtask

    function automatic void queue_row(input logic [7:0] ftype, input logic [31:0] samples);
        pending_bytes.push_back(ftype);
        for (int i = 3; i >= 0; i--)
            pending_bytes.push_back(samples[8*i +: 8]);
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick, start;
        clear_line_store();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers give a one-byte image; up on the first row sees zero above
        pending_bytes.push_back(8'(FILT_UP));
        pending_bytes.push_back(8'hFF);
        drain();

        // two 2-byte pixels, four rows: paeth on the first row, sub, average, bad type
        write_reg(CFG_BYTES_PER_PIXEL, 16'd2);
        write_reg(CFG_PIXELS_PER_ROW, 16'd2);
        write_reg(CFG_ROW_COUNT, 16'd4);
        queue_row(8'(FILT_PAETH), 32'h80FF017F);
        queue_row(8'(FILT_SUB), 32'hFF000203);
        queue_row(8'(FILT_AVG), 32'hFFFF0001);
        queue_row(8'hFF, 32'h00102030);         // bad type with every bit set, runs as none
        drain();

        // zero in every register acts as one: a one-byte image
        write_reg(CFG_BYTES_PER_PIXEL, 16'd0);
        write_reg(CFG_PIXELS_PER_ROW, 16'd0);
        write_reg(CFG_ROW_COUNT, 16'd0);
        pending_bytes.push_back(8'(FILT_NONE));
        pending_bytes.push_back(8'h5A);
        drain();

        // width shrinks mid-row below the current column: the next sample ends the row
        write_reg(CFG_BYTES_PER_PIXEL, 16'd1);
        write_reg(CFG_PIXELS_PER_ROW, 16'd4);
        write_reg(CFG_ROW_COUNT, 16'd2);
        pending_bytes.push_back(8'(FILT_UP));
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'h02);
        pending_bytes.push_back(8'h03);
        drain();
        write_reg(CFG_PIXELS_PER_ROW, 16'd2);
        pending_bytes.push_back(8'h04);
        drain();
        finish_image();
        drain();

        // widest setting: pixel size 7 acts as 4 and the row length saturates at the store
        // depth; a long stretch of that row with no random idling while the receiver holds
        // off long enough to back up the input, the row is left open for the random phases
        write_reg(CFG_BYTES_PER_PIXEL, 16'd7);
        write_reg(CFG_PIXELS_PER_ROW, 16'd8191);
        write_reg(CFG_ROW_COUNT, 16'd2);
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (WIDE_ITEMS)
            plan_step();
        drain();
        no_idle = 1'b0;

        // random phases: new registers between phases, mostly whole images,
        // some stopping mid-image or pausing mid-row
        start = planned_bytes;
        while (planned_bytes - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 60)
                write_reg(CFG_BYTES_PER_PIXEL, ($urandom_range(99) < 85) ?
                          16'($urandom_range(4, 1)) : 16'($urandom_range(7)));
            if ($urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                write_reg(CFG_PIXELS_PER_ROW, (pick < 70) ? 16'($urandom_range(6, 1)) :
                          (pick < 90) ? 16'($urandom_range(40, 7)) :
                          (pick < 95) ? 16'd0 : 16'($urandom_range(200, 64)));
            end
            if ($urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                write_reg(CFG_ROW_COUNT, (pick < 60) ? 16'($urandom_range(4, 1)) :
                          (pick < 85) ? 16'($urandom_range(10, 5)) :
                          (pick < 93) ? 16'd0 : 16'd65535);
            end
            pick = $urandom_range(9);
            if (image_height() * (row_len() + 1) > PHASE_COST || pick == 0)
            begin
                // tall or wide setting: a stretch of the stream, left open
                repeat ($urandom_range(40, 1))
                    plan_step();
            end
            else if (pick == 1)
            begin
                // sender waits mid-image until every sample is back
                repeat ($urandom_range(6, 1))
                    plan_step();
                drain();
                finish_image();
            end
            else
            begin
                finish_image();
                repeat ($urandom_range(4, 1))
                begin
                    plan_step();
                    finish_image();
                end
            end
            drain();
        end

        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
